[sv/pdps_pkg.sv]
// Shared types and constants for the pixel-depth to pan/tilt servo block.
// Used by the top level and its port checker. No dependencies.
`default_nettype none

package pdps_pkg;

   localparam int CSR_ADDR_BITS = 5;
   localparam int ZW_BITS       = 40;
   localparam int Y_BITS        = 63;
   localparam int CX_BITS       = 44;
   localparam int ANG_BITS      = 25;
   localparam int Q_BITS        = 24;
   localparam int M_BITS        = 14;
   localparam int STEPS         = 16;

   localparam logic [6:0] CMD_PAN  = 7'd85;
   localparam logic [6:0] CMD_TILT = 7'd90;

   // base angles in Q.16
   localparam logic [Q_BITS-1:0] PAN_BASE_Q16  = 24'd6553600;
   localparam logic [Q_BITS-1:0] TILT_BASE_Q16 = 24'd8192000;

   localparam logic signed [ANG_BITS-1:0] QUARTER = 25'sd5901232;
   localparam logic [63:0] XW_MAX = 64'h4000_0000_0000_0000;

   // pulse = floor(floor(q*50 / 2^16) / 9) + 1000; 1000/180 reduces to 50/9
   localparam logic [5:0]  PULSE_MUL   = 6'd50;
   localparam logic [16:0] RECIP_NINE  = 17'd116509;
   localparam int          RECIP_SHIFT = 20;
   localparam logic [15:0] PULSE_BIAS  = 16'd1000;
   localparam logic [15:0] PULSE_MAX   = 16'd2200;

   localparam logic [23:0] RST_DEPTH_SCALE = 24'd65536;
   localparam logic [15:0] RST_MIN_DEPTH   = 16'd0;
   localparam logic [11:0] RST_CENTER_X    = 12'd320;
   localparam logic [11:0] RST_CENTER_Y    = 12'd240;
   localparam logic [19:0] RST_FOCAL       = 20'd134400;
   localparam logic [23:0] RST_MOUNT       = 24'd0;

   typedef enum logic [2:0] {
      REG_DEPTH_SCALE = 3'd0,
      REG_MIN_DEPTH   = 3'd1,
      REG_CENTER_X    = 3'd2,
      REG_CENTER_Y    = 3'd3,
      REG_FOCAL_X     = 3'd4,
      REG_FOCAL_Y     = 3'd5,
      REG_MOUNT_X     = 3'd6,
      REG_MOUNT_Y     = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic y_zero;
      logic x_zero;
      logic neg;
   } axis_flags_type;

   // arctangent of 2^-i in 1/65536 of (180/3.14) per radian
   function automatic logic [21:0] atan_entry(input logic [3:0] i);
      logic [21:0] v;
      case (i)
         4'd0:  v = 22'd2950616;
         4'd1:  v = 22'd1741850;
         4'd2:  v = 22'd920346;
         4'd3:  v = 22'd467182;
         4'd4:  v = 22'd234498;
         4'd5:  v = 22'd117363;
         4'd6:  v = 22'd58696;
         4'd7:  v = 22'd29350;
         4'd8:  v = 22'd14675;
         4'd9:  v = 22'd7338;
         4'd10: v = 22'd3669;
         4'd11: v = 22'd1834;
         4'd12: v = 22'd917;
         4'd13: v = 22'd459;
         4'd14: v = 22'd229;
         default: v = 22'd115;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

[sv/pdps_if.sv]
// Valid/ready channel interfaces: target request in, servo packet out.
// No dependencies.
`default_nettype none

interface pdps_req_if #(
   parameter int PIXEL_BITS = 12,
   parameter int DEPTH_BITS = 16
);
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] pixel_x;
   logic [PIXEL_BITS-1:0] pixel_y;
   logic [DEPTH_BITS-1:0] depth_raw;

   modport source (output valid, pixel_x, pixel_y, depth_raw, input ready);
   modport sink   (input valid, pixel_x, pixel_y, depth_raw, output ready);
endinterface

interface pdps_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] command_byte;
   logic [7:0] pulse_high;
   logic [7:0] pulse_low;
   logic       last_packet;

   modport source (output valid, command_byte, pulse_high, pulse_low, last_packet,
                   input ready);
   modport sink   (input valid, command_byte, pulse_high, pulse_low, last_packet,
                   output ready);
endinterface

`default_nettype wire

[sv/pixel_depth_to_pan_tilt_servo.sv]
// Pan/tilt servo pointing from a target pixel and its raw depth sample.
// Depends on pdps_pkg and the channel interfaces in pdps_if.sv.
`default_nettype none

// Each accepted target gives two packets, pan (command 85) then tilt (command 90,
// last_packet set), each with the servo pulse split into high and low bytes.
// The datapath is a single pipeline: depth product, back-projection product,
// a one-bit-per-stage divider by the focal length (max(PIXEL_BITS,12)+48 stages),
// offset and normalisation stages, 16 CORDIC stages and a three-stage pulse scaler.
// Targets are accepted while earlier ones are still in the pipe; in steady state the
// intake rate is set by the packet port carrying two packets per target; a stall
// on rsp holds the pipe.
// Registers sit at byte address 4*index; configure only while the block is idle.

module pixel_depth_to_pan_tilt_servo #(
   parameter int PIXEL_BITS = 12,
   parameter int DEPTH_BITS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   pdps_req_if.sink                                req_chan,
   pdps_rsp_if.source                              rsp_chan,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [pdps_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [31:0]                        csr_pwdata,
   output logic      [31:0]                        csr_prdata,
   output logic                                    csr_pready
);

   localparam int DX_BITS  = ((PIXEL_BITS > 12) ? PIXEL_BITS : 12) + 1;
   localparam int ADX_BITS = DX_BITS - 1;
   localparam int ZP_BITS  = 24 + DEPTH_BITS + 1;
   localparam int P_BITS   = ADX_BITS + pdps_pkg::ZW_BITS;
   localparam int NW       = P_BITS + 8;
   localparam int ZWB      = pdps_pkg::ZW_BITS;
   localparam int CXB      = pdps_pkg::CX_BITS;
   localparam int AB       = pdps_pkg::ANG_BITS;

   // ---------------- configuration registers ----------------
   logic [23:0] depth_scale_ff, mount_x_ff, mount_y_ff;
   logic [15:0] min_depth_ff;
   logic [11:0] center_x_ff, center_y_ff;
   logic [19:0] focal_x_ff, focal_y_ff;
   logic        csr_wr;
   pdps_pkg::reg_index_type csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = pdps_pkg::reg_index_type'(csr_paddr[4:2]);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_scale_ff <= pdps_pkg::RST_DEPTH_SCALE;
         min_depth_ff   <= pdps_pkg::RST_MIN_DEPTH;
         center_x_ff    <= pdps_pkg::RST_CENTER_X;
         center_y_ff    <= pdps_pkg::RST_CENTER_Y;
         focal_x_ff     <= pdps_pkg::RST_FOCAL;
         focal_y_ff     <= pdps_pkg::RST_FOCAL;
         mount_x_ff     <= pdps_pkg::RST_MOUNT;
         mount_y_ff     <= pdps_pkg::RST_MOUNT;
      end else if (csr_wr) begin
         unique case (csr_idx)
            pdps_pkg::REG_DEPTH_SCALE: depth_scale_ff <= csr_pwdata[23:0];
            pdps_pkg::REG_MIN_DEPTH:   min_depth_ff   <= csr_pwdata[15:0];
            pdps_pkg::REG_CENTER_X:    center_x_ff    <= csr_pwdata[11:0];
            pdps_pkg::REG_CENTER_Y:    center_y_ff    <= csr_pwdata[11:0];
            pdps_pkg::REG_FOCAL_X:     focal_x_ff     <= csr_pwdata[19:0];
            pdps_pkg::REG_FOCAL_Y:     focal_y_ff     <= csr_pwdata[19:0];
            pdps_pkg::REG_MOUNT_X:     mount_x_ff     <= csr_pwdata[23:0];
            pdps_pkg::REG_MOUNT_Y:     mount_y_ff     <= csr_pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         pdps_pkg::REG_DEPTH_SCALE: csr_prdata = 32'(depth_scale_ff);
         pdps_pkg::REG_MIN_DEPTH:   csr_prdata = 32'(min_depth_ff);
         pdps_pkg::REG_CENTER_X:    csr_prdata = 32'(center_x_ff);
         pdps_pkg::REG_CENTER_Y:    csr_prdata = 32'(center_y_ff);
         pdps_pkg::REG_FOCAL_X:     csr_prdata = 32'(focal_x_ff);
         pdps_pkg::REG_FOCAL_Y:     csr_prdata = 32'(focal_y_ff);
         pdps_pkg::REG_MOUNT_X:     csr_prdata = 32'(mount_x_ff);
         pdps_pkg::REG_MOUNT_Y:     csr_prdata = 32'(mount_y_ff);
         default:                   csr_prdata = 32'd0;
      endcase
   end

   // a zero focal length counts as one
   logic [19:0] fx_eff, fy_eff;
   assign fx_eff = (focal_x_ff == 20'd0) ? 20'd1 : focal_x_ff;
   assign fy_eff = (focal_y_ff == 20'd0) ? 20'd1 : focal_y_ff;

   // ---------------- helpers ----------------
   function automatic logic signed [63:0] f_offset(input logic [NW-1:0] w, input logic neg,
                                                   input logic [23:0] mount);
      logic [63:0]        a;
      logic signed [63:0] sa, mnt;
      a = 64'(w);
      if (a > pdps_pkg::XW_MAX) a = pdps_pkg::XW_MAX;
      sa  = neg ? -signed'(a) : signed'(a);
      mnt = 64'(signed'(mount));
      return sa - (mnt <<< 8);
   endfunction

   // right shift that brings y below 2^40
   function automatic logic [4:0] f_norm_shift(input logic [pdps_pkg::Y_BITS-1:0] y);
      logic [4:0] s;
      s = 5'd0;
      for (int i = 0; i < pdps_pkg::Y_BITS - ZWB; i++) begin
         if (y[ZWB + i]) s = 5'(i + 1);
      end
      return s;
   endfunction

   function automatic logic [pdps_pkg::Q_BITS-1:0] f_angle(
      input logic signed [AB-1:0] ang, input pdps_pkg::axis_flags_type fl,
      input logic [pdps_pkg::Q_BITS-1:0] base);
      logic signed [AB-1:0] a, s;
      a = ang;
      if (a < 0) a = '0;
      if (a > pdps_pkg::QUARTER) a = pdps_pkg::QUARTER;
      if (fl.y_zero) a = '0;
      else if (fl.x_zero) a = pdps_pkg::QUARTER;
      s = fl.neg ? -a : a;
      return pdps_pkg::Q_BITS'(s + signed'(AB'(base)));
   endfunction

   // ---------------- pipeline control ----------------
   logic adv;
   logic pulse_v_ff;
   logic out_v_ff, out_tilt_ff, out_load;
   logic [15:0] pulse_p_ff, pulse_t_ff, out_pan_ff, out_tilt_pulse_ff;

   assign out_load = pulse_v_ff & (~out_v_ff | (rsp_chan.ready & out_tilt_ff));
   assign adv      = ~pulse_v_ff | out_load;
   // no item is taken while reset holds the pipe
   assign req_chan.ready = adv & ~reset;

   // ---------------- stage 1: depth product, pixel offsets ----------------
   logic               st1_v_ff;
   logic [ZP_BITS-1:0] st1_zp_ff;
   logic [ADX_BITS-1:0] st1_adp_ff, st1_adt_ff;
   logic               st1_np_ff, st1_nt_ff;
   logic [DX_BITS-1:0] dxp_in, dxt_in;

   assign dxp_in = DX_BITS'(req_chan.pixel_x) - DX_BITS'(center_x_ff);
   assign dxt_in = DX_BITS'(req_chan.pixel_y) - DX_BITS'(center_y_ff);

   always_ff @(posedge clock) begin
      if (reset) st1_v_ff <= 1'b0;
      else if (adv) st1_v_ff <= req_chan.valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st1_zp_ff  <= ZP_BITS'(depth_scale_ff) * ZP_BITS'(req_chan.depth_raw)
                       + ZP_BITS'({min_depth_ff, 16'd0});
         st1_np_ff  <= dxp_in[DX_BITS-1];
         st1_nt_ff  <= dxt_in[DX_BITS-1];
         st1_adp_ff <= ADX_BITS'(dxp_in[DX_BITS-1] ? -dxp_in : dxp_in);
         st1_adt_ff <= ADX_BITS'(dxt_in[DX_BITS-1] ? -dxt_in : dxt_in);
      end
   end

   // ---------------- stage 2: saturate depth, lateral products ----------------
   logic [63:0]    zp64;
   logic [ZWB-1:0] zw_in;

   assign zp64  = 64'(st1_zp_ff);
   assign zw_in = (|zp64[63:ZWB]) ? '1 : zp64[ZWB-1:0];

   logic           dv_v_ff  [0:NW];
   logic [ZWB-1:0] dv_zw_ff [0:NW];
   logic [NW-1:0]  dv_wp_ff [0:NW];
   logic [NW-1:0]  dv_wt_ff [0:NW];
   logic [19:0]    dv_rp_ff [0:NW];
   logic [19:0]    dv_rt_ff [0:NW];
   logic           dv_np_ff [0:NW];
   logic           dv_nt_ff [0:NW];

   always_ff @(posedge clock) begin
      if (reset) dv_v_ff[0] <= 1'b0;
      else if (adv) dv_v_ff[0] <= st1_v_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_zw_ff[0] <= zw_in;
         dv_wp_ff[0] <= {P_BITS'(st1_adp_ff) * P_BITS'(zw_in), 8'd0};
         dv_wt_ff[0] <= {P_BITS'(st1_adt_ff) * P_BITS'(zw_in), 8'd0};
         dv_rp_ff[0] <= '0;
         dv_rt_ff[0] <= '0;
         dv_np_ff[0] <= st1_np_ff;
         dv_nt_ff[0] <= st1_nt_ff;
      end
   end

   // ---------------- divider by focal length, one quotient bit a stage ----------------
   for (genvar k = 0; k < NW; k++) begin : g_div
      logic [20:0] shp, sht, dfp, dft;
      logic        gep, get;

      assign shp = {dv_rp_ff[k], dv_wp_ff[k][NW-1]};
      assign sht = {dv_rt_ff[k], dv_wt_ff[k][NW-1]};
      assign dfp = shp - {1'b0, fx_eff};
      assign dft = sht - {1'b0, fy_eff};
      assign gep = shp >= {1'b0, fx_eff};
      assign get = sht >= {1'b0, fy_eff};

      always_ff @(posedge clock) begin
         if (reset) dv_v_ff[k+1] <= 1'b0;
         else if (adv) dv_v_ff[k+1] <= dv_v_ff[k];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_zw_ff[k+1] <= dv_zw_ff[k];
            dv_np_ff[k+1] <= dv_np_ff[k];
            dv_nt_ff[k+1] <= dv_nt_ff[k];
            dv_rp_ff[k+1] <= gep ? dfp[19:0] : shp[19:0];
            dv_rt_ff[k+1] <= get ? dft[19:0] : sht[19:0];
            dv_wp_ff[k+1] <= {dv_wp_ff[k][NW-2:0], gep};
            dv_wt_ff[k+1] <= {dv_wt_ff[k][NW-2:0], get};
         end
      end
   end

   // ---------------- stage 3: signed offset minus mount ----------------
   logic               st3_v_ff;
   logic [ZWB-1:0]     st3_zw_ff;
   logic signed [63:0] st3_tp_ff, st3_tt_ff;

   always_ff @(posedge clock) begin
      if (reset) st3_v_ff <= 1'b0;
      else if (adv) st3_v_ff <= dv_v_ff[NW];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st3_zw_ff <= dv_zw_ff[NW];
         st3_tp_ff <= f_offset(dv_wp_ff[NW], dv_np_ff[NW], mount_x_ff);
         st3_tt_ff <= f_offset(dv_wt_ff[NW], dv_nt_ff[NW], mount_y_ff);
      end
   end

   // ---------------- stage 4: magnitude and normalising shift ----------------
   localparam int YB = pdps_pkg::Y_BITS;
   logic           st4_v_ff;
   logic [ZWB-1:0] st4_zw_ff;
   logic [YB-1:0]  st4_yp_ff, st4_yt_ff;
   logic [4:0]     st4_sp_ff, st4_st_ff;
   logic           st4_np_ff, st4_nt_ff;
   logic [YB-1:0]  yp_in, yt_in;

   assign yp_in = YB'(st3_tp_ff[63] ? -st3_tp_ff : st3_tp_ff);
   assign yt_in = YB'(st3_tt_ff[63] ? -st3_tt_ff : st3_tt_ff);

   always_ff @(posedge clock) begin
      if (reset) st4_v_ff <= 1'b0;
      else if (adv) st4_v_ff <= st3_v_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st4_zw_ff <= st3_zw_ff;
         st4_yp_ff <= yp_in;
         st4_yt_ff <= yt_in;
         st4_sp_ff <= f_norm_shift(yp_in);
         st4_st_ff <= f_norm_shift(yt_in);
         st4_np_ff <= st3_tp_ff[63];
         st4_nt_ff <= st3_tt_ff[63];
      end
   end

   // ---------------- stage 5 and CORDIC stages ----------------
   logic                      cr_v_ff   [0:pdps_pkg::STEPS];
   logic signed [CXB-1:0]     cr_cxp_ff [0:pdps_pkg::STEPS];
   logic signed [CXB-1:0]     cr_cyp_ff [0:pdps_pkg::STEPS];
   logic signed [CXB-1:0]     cr_cxt_ff [0:pdps_pkg::STEPS];
   logic signed [CXB-1:0]     cr_cyt_ff [0:pdps_pkg::STEPS];
   logic signed [AB-1:0]      cr_ap_ff  [0:pdps_pkg::STEPS];
   logic signed [AB-1:0]      cr_at_ff  [0:pdps_pkg::STEPS];
   pdps_pkg::axis_flags_type  cr_fp_ff  [0:pdps_pkg::STEPS];
   pdps_pkg::axis_flags_type  cr_ft_ff  [0:pdps_pkg::STEPS];

   logic [ZWB-1:0] xnp_in, ynp_in, xnt_in, ynt_in;

   assign xnp_in = st4_zw_ff >> st4_sp_ff;
   assign xnt_in = st4_zw_ff >> st4_st_ff;
   assign ynp_in = ZWB'(st4_yp_ff >> st4_sp_ff);
   assign ynt_in = ZWB'(st4_yt_ff >> st4_st_ff);

   always_ff @(posedge clock) begin
      if (reset) cr_v_ff[0] <= 1'b0;
      else if (adv) cr_v_ff[0] <= st4_v_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cr_cxp_ff[0] <= signed'(CXB'(xnp_in));
         cr_cyp_ff[0] <= signed'(CXB'(ynp_in));
         cr_cxt_ff[0] <= signed'(CXB'(xnt_in));
         cr_cyt_ff[0] <= signed'(CXB'(ynt_in));
         cr_ap_ff[0]  <= '0;
         cr_at_ff[0]  <= '0;
         cr_fp_ff[0]  <= '{y_zero: (ynp_in == '0), x_zero: (xnp_in == '0), neg: st4_np_ff};
         cr_ft_ff[0]  <= '{y_zero: (ynt_in == '0), x_zero: (xnt_in == '0), neg: st4_nt_ff};
      end
   end

   for (genvar g = 0; g < pdps_pkg::STEPS; g++) begin : g_cordic
      logic signed [AB-1:0] step;
      assign step = signed'(AB'(pdps_pkg::atan_entry(4'(g))));

      always_ff @(posedge clock) begin
         if (reset) cr_v_ff[g+1] <= 1'b0;
         else if (adv) cr_v_ff[g+1] <= cr_v_ff[g];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            cr_fp_ff[g+1] <= cr_fp_ff[g];
            cr_ft_ff[g+1] <= cr_ft_ff[g];
            if (!cr_cyp_ff[g][CXB-1]) begin
               cr_cxp_ff[g+1] <= cr_cxp_ff[g] + (cr_cyp_ff[g] >>> g);
               cr_cyp_ff[g+1] <= cr_cyp_ff[g] - (cr_cxp_ff[g] >>> g);
               cr_ap_ff[g+1]  <= cr_ap_ff[g] + step;
            end else begin
               cr_cxp_ff[g+1] <= cr_cxp_ff[g] - (cr_cyp_ff[g] >>> g);
               cr_cyp_ff[g+1] <= cr_cyp_ff[g] + (cr_cxp_ff[g] >>> g);
               cr_ap_ff[g+1]  <= cr_ap_ff[g] - step;
            end
            if (!cr_cyt_ff[g][CXB-1]) begin
               cr_cxt_ff[g+1] <= cr_cxt_ff[g] + (cr_cyt_ff[g] >>> g);
               cr_cyt_ff[g+1] <= cr_cyt_ff[g] - (cr_cxt_ff[g] >>> g);
               cr_at_ff[g+1]  <= cr_at_ff[g] + step;
            end else begin
               cr_cxt_ff[g+1] <= cr_cxt_ff[g] - (cr_cyt_ff[g] >>> g);
               cr_cyt_ff[g+1] <= cr_cyt_ff[g] + (cr_cxt_ff[g] >>> g);
               cr_at_ff[g+1]  <= cr_at_ff[g] - step;
            end
         end
      end
   end

   // ---------------- stages 6 to 8: angle to servo pulse ----------------
   localparam int QB = pdps_pkg::Q_BITS;
   localparam int MB = pdps_pkg::M_BITS;
   localparam int SL = pdps_pkg::STEPS;

   logic          st6_v_ff, st7_v_ff;
   logic [QB-1:0] st6_qp_ff, st6_qt_ff;
   logic [MB-1:0] st7_mp_ff, st7_mt_ff;
   logic [QB+5:0] mp_prod, mt_prod;
   logic [MB+16:0] pp_prod, pt_prod;

   assign mp_prod = (QB+6)'(st6_qp_ff) * (QB+6)'(pdps_pkg::PULSE_MUL);
   assign mt_prod = (QB+6)'(st6_qt_ff) * (QB+6)'(pdps_pkg::PULSE_MUL);
   assign pp_prod = (MB+17)'(st7_mp_ff) * (MB+17)'(pdps_pkg::RECIP_NINE);
   assign pt_prod = (MB+17)'(st7_mt_ff) * (MB+17)'(pdps_pkg::RECIP_NINE);

   always_ff @(posedge clock) begin
      if (reset) begin
         st6_v_ff   <= 1'b0;
         st7_v_ff   <= 1'b0;
         pulse_v_ff <= 1'b0;
      end else if (adv) begin
         st6_v_ff   <= cr_v_ff[SL];
         st7_v_ff   <= st6_v_ff;
         pulse_v_ff <= st7_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st6_qp_ff  <= f_angle(cr_ap_ff[SL], cr_fp_ff[SL], pdps_pkg::PAN_BASE_Q16);
         st6_qt_ff  <= f_angle(cr_at_ff[SL], cr_ft_ff[SL], pdps_pkg::TILT_BASE_Q16);
         st7_mp_ff  <= mp_prod[QB+5:16];
         st7_mt_ff  <= mt_prod[QB+5:16];
         pulse_p_ff <= 16'(pp_prod[MB+16:pdps_pkg::RECIP_SHIFT]) + pdps_pkg::PULSE_BIAS;
         pulse_t_ff <= 16'(pt_prod[MB+16:pdps_pkg::RECIP_SHIFT]) + pdps_pkg::PULSE_BIAS;
      end
   end

   // ---------------- packet output: pan item then tilt item ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff    <= 1'b0;
         out_tilt_ff <= 1'b0;
      end else if (out_load) begin
         out_v_ff    <= 1'b1;
         out_tilt_ff <= 1'b0;
      end else if (out_v_ff && rsp_chan.ready) begin
         if (!out_tilt_ff) out_tilt_ff <= 1'b1;
         else out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_pan_ff        <= pulse_p_ff;
         out_tilt_pulse_ff <= pulse_t_ff;
      end
   end

   logic [15:0] out_pulse;
   assign out_pulse             = out_tilt_ff ? out_tilt_pulse_ff : out_pan_ff;
   assign rsp_chan.valid        = out_v_ff;
   assign rsp_chan.command_byte = out_tilt_ff ? pdps_pkg::CMD_TILT : pdps_pkg::CMD_PAN;
   assign rsp_chan.pulse_high   = out_pulse[15:8];
   assign rsp_chan.pulse_low    = out_pulse[7:0];
   assign rsp_chan.last_packet  = out_tilt_ff;

endmodule

`default_nettype wire

[sv/pdps_checker.sv]
// Port-level checks on the servo packet channel, bound to the top level.
// Depends on pdps_pkg and pixel_depth_to_pan_tilt_servo.
`default_nettype none

module pdps_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [6:0] command_byte,
   input wire logic [7:0] pulse_high,
   input wire logic [7:0] pulse_low,
   input wire logic       last_packet
);

   logic [15:0] pulse;
   assign pulse = {pulse_high, pulse_low};

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("packet valid straight after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(command_byte)
                                  && $stable(pulse) && $stable(last_packet))
      else $error("stalled packet changed");

   a_cmd_matches_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (command_byte == pdps_pkg::CMD_PAN && !last_packet)
                 || (command_byte == pdps_pkg::CMD_TILT && last_packet))
      else $error("command byte and last flag disagree");

   a_tilt_follows_pan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !last_packet |=> rsp_valid && last_packet)
      else $error("tilt packet did not follow pan packet");

   a_pulse_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pulse >= pdps_pkg::PULSE_BIAS && pulse <= pdps_pkg::PULSE_MAX)
      else $error("servo pulse out of range");

endmodule

bind pixel_depth_to_pan_tilt_servo pdps_checker u_pdps_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .command_byte (rsp_chan.command_byte),
   .pulse_high   (rsp_chan.pulse_high),
   .pulse_low    (rsp_chan.pulse_low),
   .last_packet  (rsp_chan.last_packet)
);

`default_nettype wire
